// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL files; only the top-level reindenter unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define BDR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define BDR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bdr_pkg.sv =====
package bdr_pkg;

   localparam int CP_BITS       = 21;
   localparam int TS_BITS       = 5;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 21;
   localparam int RES_BITS      = 8;

   // register indexes on the csr port
   localparam logic [CSR_IDX_BITS-1:0] IDX_TAB_SIZE  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] IDX_RULES     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] IDX_ANCHOR    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] IDX_OPENER_A  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] IDX_OPENER_B  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] IDX_CLOSER_A  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] IDX_CLOSER_B  = 3'd6;

   localparam logic [CP_BITS-1:0] CH_SPACE = 21'd32;
   localparam logic [CP_BITS-1:0] CH_TAB   = 21'd9;

   localparam logic [TS_BITS-1:0] TS_DEFAULT = 5'd4;

   // reset values of the registers
   localparam logic [TS_BITS-1:0] RST_TAB_SIZE = 5'd4;
   localparam logic [CP_BITS-1:0] RST_OPENER_A = 21'd123;
   localparam logic [CP_BITS-1:0] RST_CLOSER_A = 21'd125;

   // per-line control bits passed from front to back
   typedef struct packed {
      logic plain;   // plain mode: level = columns / tab stop, done in the back
      logic keep;    // frozen line
   } line_flags_type;

endpackage

// ===== hdl/bdr_divider.sv =====
module bdr_divider #(
   parameter int W = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [W-1:0]                dividend,
   input  logic [bdr_pkg::TS_BITS-1:0] divisor,
   output logic                        busy,
   output logic                        done,
   output logic [W-1:0]                quotient,
   output logic [bdr_pkg::TS_BITS-1:0] remainder
);

   localparam int DW       = bdr_pkg::TS_BITS;
   localparam int CNT_BITS = $clog2(W + 1);

   logic [W-1:0]        dvd_ff, dvd_in;
   logic [DW-1:0]       dvs_ff, dvs_in;
   logic [DW-1:0]       rem_ff, rem_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DW:0]         trial;
   logic                fits;

   // restoring division, one quotient bit a cycle
   assign trial = {rem_ff, dvd_ff[W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = CNT_BITS'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DW'(trial - {1'b0, dvs_ff}) : trial[DW-1:0];
         dvd_in = {dvd_ff[W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/bdr_queue.sv =====
module bdr_queue #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic         valid,
   output logic [W-1:0] pop_data
);

   // two-entry queue
   logic [W-1:0] mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign full     = count_ff == 2'd2;
   assign valid    = count_ff != 2'd0;
   assign pop_data = mem_ff[rd_ptr_ff];

endmodule

// ===== hdl/bdr_front.sv =====
module bdr_front #(
   parameter int LEVEL_BITS  = 8,
   parameter int COLUMN_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   // item stream
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [bdr_pkg::CP_BITS-1:0]   code_point,
   input  logic                          has_char,
   input  logic                          end_of_line,
   input  logic                          range_start,
   input  logic                          line_frozen,
   // settings
   input  logic [bdr_pkg::TS_BITS-1:0]   tab_size,
   input  logic                          rules_enabled,
   input  logic [7:0]                    anchor_level,
   input  logic [bdr_pkg::CP_BITS-1:0]   opener_a,
   input  logic [bdr_pkg::CP_BITS-1:0]   opener_b,
   input  logic [bdr_pkg::CP_BITS-1:0]   closer_a,
   input  logic [bdr_pkg::CP_BITS-1:0]   closer_b,
   input  logic                          tab_write,
   // per-line queue
   input  logic                          q_full,
   output logic                          push,
   output bdr_pkg::line_flags_type       push_flags,
   output logic [LEVEL_BITS-1:0]         push_level,
   output logic [COLUMN_BITS-1:0]        push_cols,
   output logic [bdr_pkg::TS_BITS-1:0]   push_ts
);

   localparam int CPB = bdr_pkg::CP_BITS;
   localparam int TSB = bdr_pkg::TS_BITS;
   localparam int AW  = (LEVEL_BITS > 8) ? LEVEL_BITS : 8;
   localparam logic [LEVEL_BITS-1:0]  LEVEL_MAX  = '1;
   localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = '1;

   logic [LEVEL_BITS-1:0]  depth_ff, depth_in;
   logic [COLUMN_BITS-1:0] cols_ff, cols_in;
   logic [TSB-1:0]         rem_ff, rem_in;     // cols mod tab stop
   logic                   lead_ff, lead_in;   // still in leading blanks
   logic [CPB-1:0]         first_ff, first_in;
   logic [CPB-1:0]         last_ff, last_in;
   logic                   pend_ff, pend_in;   // tab stop changed, remainder stale

   logic [TSB-1:0]         ts_eff;
   logic [AW-1:0]          anchor_ext;
   logic [LEVEL_BITS-1:0]  anchor_cl;
   logic                   accept;
   logic                   blank;
   logic [TSB:0]           rem_inc;
   logic [TSB-1:0]         adv;
   logic [COLUMN_BITS:0]   col_sum;
   logic                   first_closer;
   logic                   last_opener;
   logic [LEVEL_BITS-1:0]  lvl;

   logic                   div_start;
   logic                   div_busy;
   logic                   div_done;
   logic [COLUMN_BITS-1:0] div_quot;
   logic [TSB-1:0]         div_rem;

   assign ts_eff     = (tab_size == '0) ? bdr_pkg::TS_DEFAULT : tab_size;
   assign anchor_ext = AW'(anchor_level);
   assign anchor_cl  = (anchor_ext > AW'(LEVEL_MAX)) ? LEVEL_MAX
                                                     : anchor_ext[LEVEL_BITS-1:0];

   assign in_ready  = !pend_ff && !div_busy && !div_done && !q_full;
   assign accept    = in_valid && in_ready;
   assign div_start = pend_ff;

   always_comb begin
      depth_in     = depth_ff;
      cols_in      = cols_ff;
      rem_in       = rem_ff;
      lead_in      = lead_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      pend_in      = tab_write;
      push         = 1'b0;
      push_flags   = '0;
      push_level   = '0;
      push_cols    = '0;
      push_ts      = ts_eff;
      blank        = 1'b0;
      rem_inc      = '0;
      adv          = '0;
      col_sum      = '0;
      first_closer = 1'b0;
      last_opener  = 1'b0;
      lvl          = '0;

      if (div_done && !pend_ff) begin
         rem_in = div_rem;
      end

      if (accept) begin
         if (range_start) begin
            depth_in = anchor_cl;
            cols_in  = '0;
            rem_in   = '0;
            lead_in  = 1'b1;
            first_in = '0;
            last_in  = '0;
         end

         if (has_char) begin
            blank = (code_point == bdr_pkg::CH_SPACE) || (code_point == bdr_pkg::CH_TAB);
            if (lead_in && blank) begin
               rem_inc = {1'b0, rem_in} + 1'b1;
               if (code_point == bdr_pkg::CH_SPACE) begin
                  adv    = TSB'(1);
                  rem_in = (rem_inc == {1'b0, ts_eff}) ? '0 : rem_inc[TSB-1:0];
               end else begin
                  adv    = ts_eff - rem_in;
                  rem_in = '0;
               end
               // once saturated the column count never moves again in this line
               col_sum = {1'b0, cols_in} + (COLUMN_BITS+1)'(adv);
               cols_in = (col_sum > {1'b0, COLUMN_MAX}) ? COLUMN_MAX
                                                        : col_sum[COLUMN_BITS-1:0];
            end else if (!blank) begin
               if (lead_in) begin
                  first_in = code_point;
                  lead_in  = 1'b0;
               end
               last_in = code_point;
            end
         end

         if (end_of_line) begin
            push         = 1'b1;
            first_closer = (first_in != '0) &&
                           ((first_in == closer_a) || (first_in == closer_b));
            last_opener  = (last_in != '0) &&
                           ((last_in == opener_a) || (last_in == opener_b));
            push_cols    = cols_in;
            if (!rules_enabled) begin
               push_flags.plain = 1'b1;
            end else if (line_frozen) begin
               push_flags.keep = 1'b1;
            end else if (lead_in) begin
               push_level = depth_in;
            end else begin
               lvl = depth_in;
               if (first_closer && (lvl != '0)) begin
                  lvl = lvl - 1'b1;
               end
               push_level = lvl;
               depth_in   = (last_opener && (lvl != LEVEL_MAX)) ? lvl + 1'b1 : lvl;
            end
            cols_in  = '0;
            rem_in   = '0;
            lead_in  = 1'b1;
            first_in = '0;
            last_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         cols_ff  <= '0;
         rem_ff   <= '0;
         lead_ff  <= 1'b1;
         first_ff <= '0;
         last_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         cols_ff  <= cols_in;
         rem_ff   <= rem_in;
         lead_ff  <= lead_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         pend_ff  <= pend_in;
      end
   end

   // recomputes cols mod tab stop after the tab size changes mid-line
   bdr_divider #(
      .W (COLUMN_BITS)
   ) u_rem_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cols_ff),
      .divisor   (ts_eff),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // quotient is not needed here; it only keeps the divider's outputs in use
   logic unused_quot;
   assign unused_quot = ^div_quot;

endmodule

// ===== hdl/bdr_back.sv =====
module bdr_back #(
   parameter int LEVEL_BITS  = 8,
   parameter int COLUMN_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // per-line queue
   input  logic                                 q_valid,
   output logic                                 q_pop,
   input  bdr_pkg::line_flags_type              q_flags,
   input  logic [LEVEL_BITS-1:0]                q_level,
   input  logic [COLUMN_BITS-1:0]               q_cols,
   input  logic [bdr_pkg::TS_BITS-1:0]          q_ts,
   // results
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [bdr_pkg::RES_BITS-1:0]         rsp_level,
   output logic                                 rsp_keep
);

   localparam int RB  = bdr_pkg::RES_BITS;
   localparam int LW  = (LEVEL_BITS > RB) ? LEVEL_BITS : RB;
   localparam int CAP = (((1 << LEVEL_BITS) - 1) < 255) ? ((1 << LEVEL_BITS) - 1) : 255;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RB-1:0] rsp_level_ff, rsp_level_in;
   logic          rsp_keep_ff, rsp_keep_in;

   logic                   out_free;
   logic [LW-1:0]          lvl_ext;
   logic [RB-1:0]          lvl_cap;
   logic [RB-1:0]          quot_cap;
   logic                   div_start;
   logic                   div_busy;
   logic                   div_done;
   logic [COLUMN_BITS-1:0] div_quot;
   logic [bdr_pkg::TS_BITS-1:0] div_rem;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign lvl_ext  = LW'(q_level);
   assign lvl_cap  = (lvl_ext > LW'(255)) ? 8'hFF : lvl_ext[RB-1:0];
   assign quot_cap = (div_quot > COLUMN_BITS'(CAP)) ? RB'(CAP) : div_quot[RB-1:0];

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_level_in = rsp_level_ff;
      rsp_keep_in  = rsp_keep_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_flags.plain) begin
                  q_pop     = 1'b1;
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else if (out_free) begin
                  q_pop        = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_level_in = lvl_cap;
                  rsp_keep_in  = q_flags.keep;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = quot_cap;
               rsp_keep_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_level_ff <= rsp_level_in;
      rsp_keep_ff  <= rsp_keep_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // columns / tab stop for plain-mode lines
   bdr_divider #(
      .W (COLUMN_BITS)
   ) u_lvl_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (q_cols),
      .divisor   (q_ts),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // remainder and busy unused here
   logic unused_div;
   assign unused_div = div_busy ^ (^div_rem);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;
   assign rsp_keep  = rsp_keep_ff;

endmodule

// ===== hdl/brace_depth_reindenter_unit.sv =====
// Brace-depth reindenter. Text streams in one code point per transfer on
// req_, the last item of each line flagged by req_tlast, and each finished
// line gives one transfer on rsp_ with its indent level. With rules on, a
// running brace depth (reloaded from anchor_level by range_start) sets the
// level: a line that starts with a closer sits one level out, a line that
// ends with an opener pushes the next line in, blank lines keep the depth,
// frozen lines come out as level 0 with keep_as_is set. With rules off the
// level is the line's leading whitespace in tab stops (tab size 0 means 4).
// Rate: the scanning front takes one item per cycle while the line queue has
// room and no tab remainder is being rebuilt. A plain-mode line is held in the
// back by its bit-serial divider; the two-entry line queue lets the front keep
// scanning while a line is divided, so short lines in plain mode throttle the
// input. Rules-mode lines skip the divider in the back. A write to tab_size
// holds req_tready low while the in-line tab remainder is rebuilt. No clearing
// pass after reset. csr_ready is always high.
`include "assert_macros.svh"

module brace_depth_reindenter_unit #(
   parameter int LEVEL_BITS  = 8,
   parameter int COLUMN_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,  // [20:0] code_point, rest zero
   input  logic [2:0]                          req_tuser,  // [0] has_char, [1] range_start,
                                                           // [2] line_frozen
   input  logic                                req_tlast,  // end_of_line
   // results
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,  // [7:0] indent_level
   output logic                                rsp_tuser,  // [0] keep_as_is
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bdr_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [bdr_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int CPB = bdr_pkg::CP_BITS;
   localparam int TSB = bdr_pkg::TS_BITS;
   localparam int QW  = TSB + COLUMN_BITS + LEVEL_BITS + $bits(bdr_pkg::line_flags_type);

   // configuration registers
   logic [TSB-1:0] tab_size_ff;
   logic           rules_ff;
   logic [7:0]     anchor_ff;
   logic [CPB-1:0] opener_a_ff;
   logic [CPB-1:0] opener_b_ff;
   logic [CPB-1:0] closer_a_ff;
   logic [CPB-1:0] closer_b_ff;

   logic csr_xfer;
   logic tab_write;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;
   assign tab_write = csr_xfer && (csr_index == bdr_pkg::IDX_TAB_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_size_ff <= bdr_pkg::RST_TAB_SIZE;
         rules_ff    <= 1'b1;
         anchor_ff   <= '0;
         opener_a_ff <= bdr_pkg::RST_OPENER_A;
         opener_b_ff <= '0;
         closer_a_ff <= bdr_pkg::RST_CLOSER_A;
         closer_b_ff <= '0;
      end else if (csr_xfer) begin
         case (csr_index)
            bdr_pkg::IDX_TAB_SIZE: tab_size_ff <= csr_data[TSB-1:0];
            bdr_pkg::IDX_RULES:    rules_ff    <= csr_data[0];
            bdr_pkg::IDX_ANCHOR:   anchor_ff   <= csr_data[7:0];
            bdr_pkg::IDX_OPENER_A: opener_a_ff <= csr_data[CPB-1:0];
            bdr_pkg::IDX_OPENER_B: opener_b_ff <= csr_data[CPB-1:0];
            bdr_pkg::IDX_CLOSER_A: closer_a_ff <= csr_data[CPB-1:0];
            bdr_pkg::IDX_CLOSER_B: closer_b_ff <= csr_data[CPB-1:0];
            default: ;  // unknown index: write dropped
         endcase
      end
   end

   // front -> queue
   logic                        f_push;
   bdr_pkg::line_flags_type     f_flags;
   logic [LEVEL_BITS-1:0]       f_level;
   logic [COLUMN_BITS-1:0]      f_cols;
   logic [TSB-1:0]              f_ts;
   logic                        q_full;
   logic                        q_valid;
   logic                        q_pop;
   logic [QW-1:0]               q_in;
   logic [QW-1:0]               q_out;
   bdr_pkg::line_flags_type     b_flags;
   logic [LEVEL_BITS-1:0]       b_level;
   logic [COLUMN_BITS-1:0]      b_cols;
   logic [TSB-1:0]              b_ts;

   // scanning front: one item per cycle while req_tready is high, finishes rules-mode levels itself
   bdr_front #(
      .LEVEL_BITS  (LEVEL_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .code_point    (req_tdata[CPB-1:0]),
      .has_char      (req_tuser[0]),
      .end_of_line   (req_tlast),
      .range_start   (req_tuser[1]),
      .line_frozen   (req_tuser[2]),
      .tab_size      (tab_size_ff),
      .rules_enabled (rules_ff),
      .anchor_level  (anchor_ff),
      .opener_a      (opener_a_ff),
      .opener_b      (opener_b_ff),
      .closer_a      (closer_a_ff),
      .closer_b      (closer_b_ff),
      .tab_write     (tab_write),
      .q_full        (q_full),
      .push          (f_push),
      .push_flags    (f_flags),
      .push_level    (f_level),
      .push_cols     (f_cols),
      .push_ts       (f_ts)
   );

   assign q_in = {f_ts, f_cols, f_level, f_flags};

   bdr_queue #(
      .W (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_out)
   );

   assign {b_ts, b_cols, b_level, b_flags} = q_out;

   // back: plain-mode division and the output register
   bdr_back #(
      .LEVEL_BITS  (LEVEL_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_flags   (b_flags),
      .q_level   (b_level),
      .q_cols    (b_cols),
      .q_ts      (b_ts),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_level (rsp_tdata),
      .rsp_keep  (rsp_tuser)
   );

   // checks
   `BDR_ASSERT_NOW(a_no_overflow, clock, reset, f_push, !q_full, "line queue overflow")
   `BDR_ASSERT_NOW(a_ready_room, clock, reset, req_tready, !q_full, "ready with queue full")
   `BDR_ASSERT_NOW(a_keep_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == 8'd0,
                   "frozen line with nonzero level")
   `BDR_ASSERT_NEXT(a_rst_idle, clock, 1'b0, reset, !rsp_tvalid && !q_valid,
                    "result pending after reset")

endmodule
